@@ rtl/core/rpq_pkg.sv @@
// ----------------------------------------------------------------------------
// rpq_pkg
// shared types and codes of the record priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package rpq_pkg;

    localparam int FIELD_W    = 32;
    localparam int ACT_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOWEST   = 2'd1;

    localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 5'd16;

    // field order gives the lexicographic sort order
    typedef struct packed {
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] runtime;
        logic [FIELD_W-1:0] ident;
    } t_rec;

    typedef struct packed {
        logic                load;        // latch the accepted word
        logic                do_insert;   // append record
        logic                scan_start;  // reset scan pointer and best
        logic                scan_step;   // one read and one compare
        logic                move_read;   // read last stored entry
        logic                move_write;  // fill the gap, drop count
        logic                res_set;     // set result status
        logic [STATUS_W-1:0] res_status;
        logic                res_hit;     // result carries the best record
        logic                out_load;    // move result to output register
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             is_empty;
        logic             is_full;
        logic             scan_done;
        logic             out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/rpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpq_ctrl
// sequencer for insert, scan and gap fill of the record priority queue
// ----------------------------------------------------------------------------
`default_nettype none

module rpq_ctrl
    import rpq_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MOVER = 3'd3;
    localparam logic [2:0] S_MOVEW = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.act)
                    ACT_INSERT: begin
                        o_cmd.res_set = 1'b1;
                        if (i_stat.is_full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.res_status = ST_OK;
                            o_cmd.do_insert  = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    ACT_REMOVE, ACT_PEEK: begin
                        if (i_stat.is_empty) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        // unused code: no change, plain ok result
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_hit    = 1'b1;
                    n_state = (i_stat.act == ACT_REMOVE) ? S_MOVER : S_DONE;
                end
            end
            S_MOVER: begin
                o_cmd.move_read = 1'b1;
                n_state         = S_MOVEW;
            end
            S_MOVEW: begin
                o_cmd.move_write = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/rpq_dp.sv @@
// ----------------------------------------------------------------------------
// rpq_dp
// record store, scan comparator, entry count and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rpq_dp
    import rpq_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [ACT_W-1:0]       i_action,
    input  wire [FIELD_W-1:0]     i_arrival_in,
    input  wire [FIELD_W-1:0]     i_runtime_in,
    input  wire [FIELD_W-1:0]     i_ident_in,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [FIELD_W-1:0]    o_arrival_out,
    output logic [FIELD_W-1:0]    o_runtime_out,
    output logic [FIELD_W-1:0]    o_ident_out,
    output logic [OCC_W-1:0]      o_occupancy
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

    t_rec r_mem [MAX_ENTRIES];

    logic [CFG_DATA_W-1:0] r_cap;
    logic                  r_lowest;
    logic [ACT_W-1:0]      r_act;
    t_rec                  r_in_rec;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_scan_addr;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_rd_vld;
    t_rec                  r_rd_data;
    t_rec                  r_best;
    logic [AW-1:0]         r_best_idx;
    logic                  r_best_vld;
    logic [STATUS_W-1:0]   r_res_status;
    logic                  r_res_hit;
    logic                  r_out_vld;

    logic [CW-1:0] w_last;
    logic [XW-1:0] w_cap_ext;
    logic [XW-1:0] w_cap_eff;
    logic [AW-1:0] w_rd_addr;
    logic          w_we;
    logic [AW-1:0] w_wr_addr;
    t_rec          w_wr_data;
    logic          w_better;

    assign w_last    = r_count - CW'(1);
    assign w_cap_ext = XW'(r_cap);

    // capacity clamped to the range one to the store depth
    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = XW'(1);
        end else if (w_cap_ext > XW'(MAX_ENTRIES)) begin
            w_cap_eff = XW'(MAX_ENTRIES);
        end else begin
            w_cap_eff = w_cap_ext;
        end
    end

    assign w_rd_addr = i_cmd.move_read ? w_last[AW-1:0] : r_scan_addr[AW-1:0];
    assign w_we      = i_cmd.do_insert | i_cmd.move_write;
    assign w_wr_addr = i_cmd.do_insert ? r_count[AW-1:0] : r_best_idx;
    assign w_wr_data = i_cmd.do_insert ? r_in_rec : r_rd_data;

    // strict compare keeps the earliest of equal records
    assign w_better = !r_best_vld ||
                      (r_lowest ? (r_rd_data < r_best) : (r_rd_data > r_best));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAPACITY_RESET;
            r_lowest   <= 1'b0;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_CAPACITY) begin
                    r_cap <= i_cfg_data;
                end else if (i_cfg_idx == CFG_IDX_LOWEST) begin
                    r_lowest <= i_cfg_data[0];
                end
            end
            if (i_cmd.do_insert) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.move_write) begin
                r_count <= w_last;
            end
            if (i_cmd.scan_start) begin
                r_rd_vld   <= 1'b0;
                r_best_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= (r_scan_addr < r_count);
                if (r_rd_vld && w_better) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_action;
            r_in_rec <= '{arrival: i_arrival_in, runtime: i_runtime_in,
                          ident: i_ident_in};
        end
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + CW'(1);
            r_rd_idx    <= r_scan_addr[AW-1:0];
            if (r_rd_vld && w_better) begin
                r_best     <= r_rd_data;
                r_best_idx <= r_rd_idx;
            end
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_hit    <= i_cmd.res_hit;
        end
        if (i_cmd.out_load) begin
            o_status      <= r_res_status;
            o_arrival_out <= r_res_hit ? r_best.arrival : '0;
            o_runtime_out <= r_res_hit ? r_best.runtime : '0;
            o_ident_out   <= r_res_hit ? r_best.ident : '0;
            o_occupancy   <= OCC_W'(r_count);
        end
    end

    assign o_valid = r_out_vld;

    assign o_stat.act       = r_act;
    assign o_stat.is_empty  = (r_count == '0);
    assign o_stat.is_full   = (XW'(r_count) >= w_cap_eff);
    assign o_stat.scan_done = r_rd_vld && (CW'(r_rd_idx) == w_last);
    assign o_stat.out_free  = !r_out_vld || i_ready;

endmodule

`default_nettype wire

@@ rtl/core/record_priority_queue.sv @@
// ----------------------------------------------------------------------------
// record_priority_queue
// bounded priority queue of process records kept as an unsorted array
// ----------------------------------------------------------------------------
//
//  channel   direction   handshake           payload
//  -------   ---------   -----------------   -------------------------------
//  input     in          i_valid / o_ready   action, arrival, runtime, ident
//  result    out         o_valid / i_ready   status, record, occupancy
//  config    in          i_cfg_we            i_cfg_idx, i_cfg_data
//
//  insert, full, empty or unused code: decided in the execute state, no scan
//  peek and remove scan the store (remove then fills the gap) with the single
//  comparator that walks the store one entry per cycle behind its read port
//  one word at a time; a new word is taken while the last result waits
//  reset empties the queue, capacity 16, greatest record served first
//  a stalled result holds the sequencer in its final state
//
// ----------------------------------------------------------------------------
`default_nettype none

module record_priority_queue
    import rpq_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input word
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire [ACT_W-1:0]       i_action,
    input  wire [FIELD_W-1:0]     i_arrival_in,
    input  wire [FIELD_W-1:0]     i_runtime_in,
    input  wire [FIELD_W-1:0]     i_ident_in,
    // configuration writes
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    // result word
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [FIELD_W-1:0]    o_arrival_out,
    output logic [FIELD_W-1:0]    o_runtime_out,
    output logic [FIELD_W-1:0]    o_ident_out,
    output logic [OCC_W-1:0]      o_occupancy
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: decides per action, runs the scan, fills the removed slot
    rpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // store, count and comparator; a remove moves the last entry into the
    // gap, equal records are identical so the served order is unchanged
    rpq_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_arrival_in  (i_arrival_in),
        .i_runtime_in  (i_runtime_in),
        .i_ident_in    (i_ident_in),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_arrival_out (o_arrival_out),
        .o_runtime_out (o_runtime_out),
        .o_ident_out   (o_ident_out),
        .o_occupancy   (o_occupancy)
    );

    // a failed (full or empty) result never carries a record
    a_zero_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_arrival_out == '0 && o_runtime_out == '0 && o_ident_out == '0))
        else $error("record on a non-ok result");

    // one word in flight: ready drops right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word accepted while busy");

    // empty status only with no stored records
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with stored records");

    // full status only with stored records
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_occupancy != '0))
        else $error("full status on an empty queue");

endmodule

`default_nettype wire
